FILE: sv/spfl_pkg.sv
// ----------------------------------------------------------------------------
// spfl_pkg: shared definitions for the slot pool free list
// Field widths, the default pool size, and the operation and status codes.
// ----------------------------------------------------------------------------
package spfl_pkg;

  // Default number of slots in the pool, sentinel slot 0 included.
  localparam int SlotsDefault = 1024;

  // Fixed widths of the request and result fields.
  localparam int FuncW   = 2;
  localparam int SlotW   = 10;
  localparam int StatusW = 2;
  localparam int CountW  = 10;

  // Operation codes carried by a request.
  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_PIN     = 2'd2
  } func_e;

  // Status codes carried by a result.
  typedef enum logic [StatusW-1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_EMPTY      = 2'd1,
    STATUS_INELIGIBLE = 2'd2
  } status_e;

endpackage

FILE: sv/spfl_link_mem.sv
// ----------------------------------------------------------------------------
// spfl_link_mem: link storage of the slot pool
// Two synchronous memories with one read and one write port each. The next
// memory holds the next link and the live flag of a slot, written under
// separate enables; the prev memory holds the prev link. Reads at one shared
// address return registered data in the next cycle.
// ----------------------------------------------------------------------------
module spfl_link_mem #(
  parameter int   SLOTS = spfl_pkg::SlotsDefault,
  localparam int  LinkW = $clog2(SLOTS)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [LinkW-1:0] rd_addr_i,
  input  logic             nx_we_i,
  input  logic             nx_live_we_i,
  input  logic [LinkW-1:0] nx_addr_i,
  input  logic [LinkW-1:0] nx_link_i,
  input  logic             nx_live_i,
  input  logic             pv_we_i,
  input  logic [LinkW-1:0] pv_addr_i,
  input  logic [LinkW-1:0] pv_link_i,
  output logic [LinkW-1:0] nx_link_o,
  output logic             nx_live_o,
  output logic [LinkW-1:0] pv_link_o
);

  // Next memory word: live flag on top, next link below.
  logic [LinkW:0]   next_mem [SLOTS];
  logic [LinkW-1:0] prev_mem [SLOTS];
  logic [LinkW:0]   next_rd_q;
  logic [LinkW-1:0] prev_rd_q;

  // Next memory: link and live flag are written under their own enables.
  always_ff @(posedge clk_i) begin
    if (nx_we_i) begin
      next_mem[nx_addr_i][LinkW-1:0] <= nx_link_i;
    end
    if (nx_live_we_i) begin
      next_mem[nx_addr_i][LinkW] <= nx_live_i;
    end
    if (rd_en_i) begin
      next_rd_q <= next_mem[rd_addr_i];
    end
  end

  // Prev memory.
  always_ff @(posedge clk_i) begin
    if (pv_we_i) begin
      prev_mem[pv_addr_i] <= pv_link_i;
    end
    if (rd_en_i) begin
      prev_rd_q <= prev_mem[rd_addr_i];
    end
  end

  assign nx_link_o = next_rd_q[LinkW-1:0];
  assign nx_live_o = next_rd_q[LinkW];
  assign pv_link_o = prev_rd_q;

endmodule

FILE: sv/spfl_seq.sv
// ----------------------------------------------------------------------------
// spfl_seq: request sequencer of the slot pool
// Runs the clearing pass after reset, then takes one request at a time:
// it reads the addressed slot, decides, and writes the links back in a first
// and a second round. Holds the list head, free count and result register.
// ----------------------------------------------------------------------------
module spfl_seq #(
  parameter int   SLOTS = spfl_pkg::SlotsDefault,
  localparam int  LinkW = $clog2(SLOTS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [spfl_pkg::FuncW-1:0]   func_i,
  input  logic [spfl_pkg::SlotW-1:0]   slot_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [spfl_pkg::StatusW-1:0] status_o,
  output logic [spfl_pkg::SlotW-1:0]   granted_slot_o,
  output logic                         evict_needed_o,
  output logic [spfl_pkg::CountW-1:0]  free_count_o,
  // Link memory port.
  output logic                         rd_en_o,
  output logic [LinkW-1:0]             rd_addr_o,
  output logic                         nx_we_o,
  output logic                         nx_live_we_o,
  output logic [LinkW-1:0]             nx_addr_o,
  output logic [LinkW-1:0]             nx_link_o,
  output logic                         nx_live_o,
  output logic                         pv_we_o,
  output logic [LinkW-1:0]             pv_addr_o,
  output logic [LinkW-1:0]             pv_link_o,
  input  logic [LinkW-1:0]             nx_link_i,
  input  logic                         nx_live_i,
  input  logic [LinkW-1:0]             pv_link_i
);

  localparam logic [LinkW-1:0] LastIdx  = LinkW'(SLOTS - 1);
  localparam logic [LinkW-1:0] FirstIdx = LinkW'(1);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [LinkW-1:0]               clr_q, clr_d;
  logic [LinkW-1:0]               head_q, head_d;
  logic [LinkW-1:0]               total_q, total_d;
  logic [spfl_pkg::FuncW-1:0]     func_q, func_d;
  logic [spfl_pkg::SlotW-1:0]     slot_q, slot_d;
  logic [LinkW-1:0]               idx_q, idx_d;
  logic                           ok_q, ok_d;
  logic [LinkW-1:0]               nlink_q, nlink_d;
  logic [LinkW-1:0]               plink_q, plink_d;
  logic                           live_q, live_d;
  logic                           out_valid_q, out_valid_d;
  logic [spfl_pkg::StatusW-1:0]   status_q, status_d;
  logic [spfl_pkg::SlotW-1:0]     granted_q, granted_d;
  logic                           evict_q, evict_d;
  logic [spfl_pkg::CountW-1:0]    count_q, count_d;

  logic [31:0] slot_ext;
  logic [31:0] grant_ext;
  logic [31:0] count_ext;
  logic        on_list;
  logic        usable;
  logic        advance;

  // Width conversions between the 10-bit fields and the link width.
  assign slot_ext  = 32'(slot_i);
  assign grant_ext = 32'(idx_q);

  // Eligibility of the captured slot, from the read data.
  assign on_list = (nx_link_i != '0) || (pv_link_i != '0) || (head_q == idx_q);
  assign usable  = (slot_q != '0) && (32'(slot_q) < 32'(SLOTS));
  assign advance = !out_valid_q || out_ready_i;

  // Next state, memory accesses and result.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    head_d      = head_q;
    total_d     = total_q;
    func_d      = func_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    ok_d        = ok_q;
    nlink_d     = nlink_q;
    plink_d     = plink_q;
    live_d      = live_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    granted_d   = granted_q;
    evict_d     = evict_q;
    count_d     = count_q;
    count_ext   = 32'(total_q);

    rd_en_o      = 1'b0;
    rd_addr_o    = idx_q;
    nx_we_o      = 1'b0;
    nx_live_we_o = 1'b0;
    nx_addr_o    = idx_q;
    nx_link_o    = '0;
    nx_live_o    = 1'b0;
    pv_we_o      = 1'b0;
    pv_addr_o    = idx_q;
    pv_link_o    = '0;

    case (state_q)
      // Clearing pass: build the initial chain, one slot a cycle.
      ST_INIT: begin
        nx_we_o      = 1'b1;
        nx_live_we_o = 1'b1;
        nx_addr_o    = clr_q;
        nx_link_o    = ((clr_q == '0) || (clr_q == LastIdx)) ? '0 : clr_q + FirstIdx;
        nx_live_o    = 1'b0;
        pv_we_o      = 1'b1;
        pv_addr_o    = clr_q;
        pv_link_o    = (clr_q == '0) ? '0 : clr_q - FirstIdx;
        if (clr_q == LastIdx) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + FirstIdx;
        end
      end

      // Take a request and read its slot; allocate reads the list head.
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d    = func_i;
          slot_d    = slot_i;
          idx_d     = (func_i == spfl_pkg::FUNC_ALLOC) ? head_q : slot_ext[LinkW-1:0];
          rd_en_o   = 1'b1;
          rd_addr_o = idx_d;
          state_d   = ST_EXEC;
        end
      end

      // Read data is here: decide and do the first round of writes.
      ST_EXEC: begin
        nlink_d = nx_link_i;
        plink_d = pv_link_i;
        live_d  = nx_live_i;
        case (func_q)
          spfl_pkg::FUNC_ALLOC: begin
            ok_d = (head_q != '0);
            if (ok_d) begin
              nx_we_o      = 1'b1;
              nx_live_we_o = 1'b1;
              nx_addr_o    = idx_q;
              nx_link_o    = '0;
              nx_live_o    = 1'b1;
              pv_we_o      = 1'b1;
              pv_addr_o    = idx_q;
              pv_link_o    = '0;
            end
          end
          spfl_pkg::FUNC_RELEASE: begin
            ok_d = usable && !on_list;
            if (ok_d) begin
              nx_we_o   = 1'b1;
              nx_addr_o = idx_q;
              nx_link_o = head_q;
            end
          end
          spfl_pkg::FUNC_PIN: begin
            ok_d = usable && on_list;
            if (ok_d && (nx_link_i != '0)) begin
              pv_we_o   = 1'b1;
              pv_addr_o = nx_link_i;
              pv_link_o = pv_link_i;
            end
            if (ok_d && (pv_link_i != '0)) begin
              nx_we_o   = 1'b1;
              nx_addr_o = pv_link_i;
              nx_link_o = nx_link_i;
            end
          end
          default: begin
            ok_d = 1'b0;
          end
        endcase
        state_d = ST_FINISH;
      end

      // Second round of writes, head and count update, result load.
      ST_FINISH: begin
        if (advance) begin
          granted_d = '0;
          evict_d   = 1'b0;
          if (ok_q) begin
            case (func_q)
              spfl_pkg::FUNC_ALLOC: begin
                pv_we_o   = 1'b1;
                pv_addr_o = nlink_q;
                pv_link_o = '0;
                head_d    = nlink_q;
                total_d   = total_q - FirstIdx;
                granted_d = grant_ext[spfl_pkg::SlotW-1:0];
                evict_d   = live_q;
              end
              spfl_pkg::FUNC_RELEASE: begin
                if (head_q != '0) begin
                  pv_we_o   = 1'b1;
                  pv_addr_o = head_q;
                  pv_link_o = idx_q;
                end
                head_d  = idx_q;
                total_d = total_q + FirstIdx;
              end
              spfl_pkg::FUNC_PIN: begin
                nx_we_o   = 1'b1;
                nx_addr_o = idx_q;
                nx_link_o = '0;
                pv_we_o   = 1'b1;
                pv_addr_o = idx_q;
                pv_link_o = '0;
                if (plink_q == '0) begin
                  head_d = nlink_q;
                end
                total_d = total_q - FirstIdx;
              end
              default: begin
                head_d = head_q;
              end
            endcase
            status_d = spfl_pkg::STATUS_DONE;
          end else if (func_q == spfl_pkg::FUNC_ALLOC) begin
            status_d = spfl_pkg::STATUS_EMPTY;
          end else begin
            status_d = spfl_pkg::STATUS_INELIGIBLE;
          end
          count_ext   = 32'(total_d);
          count_d     = count_ext[spfl_pkg::CountW-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      head_q      <= FirstIdx;
      total_q     <= LastIdx;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    slot_q    <= slot_d;
    idx_q     <= idx_d;
    ok_q      <= ok_d;
    nlink_q   <= nlink_d;
    plink_q   <= plink_d;
    live_q    <= live_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    evict_q   <= evict_d;
    count_q   <= count_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign granted_slot_o = granted_q;
  assign evict_needed_o = evict_q;
  assign free_count_o   = count_q;

endmodule

FILE: sv/slot_pool_free_list_core.sv
// ----------------------------------------------------------------------------
// slot_pool_free_list_core: slot allocator with a doubly linked free list
// Allocate pops the list head, release pushes a slot, pin unlinks a slot
// from anywhere in the list. Links and live flags sit in link memories.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+---------------------------------
//   request  | in_valid_i / in_ready_o   | func_i, slot_i
//   result   | out_valid_o / out_ready_i | status_o, granted_slot_o,
//            |                           | evict_needed_o, free_count_o
//
// Each request takes a read of the link memories, then a first and a second
// round of writes, since an unlink touches both neighbors through one write
// port per memory. One request is in flight at a time.
// After reset a clearing pass writes the initial chain over every slot;
// no request is taken during it.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls in its last cycle until the output register is free.
// ----------------------------------------------------------------------------
module slot_pool_free_list_core #(
  parameter int SLOTS = spfl_pkg::SlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [spfl_pkg::FuncW-1:0]   func_i,
  input  logic [spfl_pkg::SlotW-1:0]   slot_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [spfl_pkg::StatusW-1:0] status_o,
  output logic [spfl_pkg::SlotW-1:0]   granted_slot_o,
  output logic                         evict_needed_o,
  output logic [spfl_pkg::CountW-1:0]  free_count_o
);

  localparam int LinkW = $clog2(SLOTS);

  logic             rd_en;
  logic [LinkW-1:0] rd_addr;
  logic             nx_we;
  logic             nx_live_we;
  logic [LinkW-1:0] nx_addr;
  logic [LinkW-1:0] nx_wlink;
  logic             nx_wlive;
  logic             pv_we;
  logic [LinkW-1:0] pv_addr;
  logic [LinkW-1:0] pv_wlink;
  logic [LinkW-1:0] nx_rlink;
  logic             nx_rlive;
  logic [LinkW-1:0] pv_rlink;

  // Sequencer: list head, free count, result register.
  spfl_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .slot_i        (slot_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .granted_slot_o(granted_slot_o),
    .evict_needed_o(evict_needed_o),
    .free_count_o  (free_count_o),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .nx_we_o       (nx_we),
    .nx_live_we_o  (nx_live_we),
    .nx_addr_o     (nx_addr),
    .nx_link_o     (nx_wlink),
    .nx_live_o     (nx_wlive),
    .pv_we_o       (pv_we),
    .pv_addr_o     (pv_addr),
    .pv_link_o     (pv_wlink),
    .nx_link_i     (nx_rlink),
    .nx_live_i     (nx_rlive),
    .pv_link_i     (pv_rlink)
  );

  // Link memories.
  spfl_link_mem #(
    .SLOTS(SLOTS)
  ) u_link_mem (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .nx_we_i     (nx_we),
    .nx_live_we_i(nx_live_we),
    .nx_addr_i   (nx_addr),
    .nx_link_i   (nx_wlink),
    .nx_live_i   (nx_wlive),
    .pv_we_i     (pv_we),
    .pv_addr_i   (pv_addr),
    .pv_link_i   (pv_wlink),
    .nx_link_o   (nx_rlink),
    .nx_live_o   (nx_rlive),
    .pv_link_o   (pv_rlink)
  );

  // One request in flight: taking a request drops ready in the next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while another is in flight");

  // An empty list reports a free count of zero.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == spfl_pkg::STATUS_EMPTY)) |-> (free_count_o == '0))
    else $error("empty status with nonzero free count");

  // Only a completed request carries a granted slot or an eviction.
  a_grant_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((granted_slot_o != '0) || evict_needed_o))
      |-> (status_o == spfl_pkg::STATUS_DONE))
    else $error("granted slot or eviction on a failed request");

endmodule
